@@ sv/lsd_pkg.sv @@
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types and constants for the LIFO stack with dump.
// ----------------------------------------------------------------------------
package lsd_pkg;

    localparam int DEPTH    = 64;
    localparam int WORD_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_DUMP = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_ONES,
        SEL_RAM
    } data_sel_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic      push;
        logic      pop;
        logic      dump_start;
        logic      dump_step;
        logic      out_load;
        status_t   out_status;
        data_sel_t out_sel;
        logic      out_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic idx_zero;
        logic out_free;
    } dp_status_t;

endpackage

@@ sv/lsd_cmd_if.sv @@
// ----------------------------------------------------------------------------
// lsd_cmd_if
// Request channel: one stack operation and its push value per transaction.
// ----------------------------------------------------------------------------
interface lsd_cmd_if;
    import lsd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

@@ sv/lsd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lsd_rsp_if
// Response channel: one status, data word and last flag per transaction.
// ----------------------------------------------------------------------------
interface lsd_rsp_if;
    import lsd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] data;
    logic                     last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

@@ sv/lsd_ram.sv @@
// ----------------------------------------------------------------------------
// lsd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ sv/lsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsd_ctrl
// Controller state machine: decodes requests and sequences pops and dumps.
// ----------------------------------------------------------------------------
module lsd_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  logic [lsd_pkg::OP_W-1:0] cmd_operation,
    output logic                    cmd_ready,
    input  lsd_pkg::dp_status_t     dp_status,
    output lsd_pkg::ctrl_cmd_t      ctrl_cmd
);
    import lsd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_ready  = 1'b0;
        ctrl_cmd   = '{push: 1'b0, pop: 1'b0, dump_start: 1'b0, dump_step: 1'b0,
                       out_load: 1'b0, out_status: ST_OK, out_sel: SEL_ZERO,
                       out_last: 1'b1};
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = dp_status.out_free;
                if (cmd_valid && dp_status.out_free)
                begin
                    case (cmd_operation)
                        OP_PUSH:
                        begin
                            ctrl_cmd.out_load = 1'b1;
                            if (dp_status.full)
                            begin
                                ctrl_cmd.out_status = ST_OVERFLOW;
                            end
                            else
                            begin
                                ctrl_cmd.push = 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (dp_status.empty)
                            begin
                                ctrl_cmd.out_load   = 1'b1;
                                ctrl_cmd.out_status = ST_UNDERFLOW;
                                ctrl_cmd.out_sel    = SEL_ONES;
                            end
                            else
                            begin
                                ctrl_cmd.pop = 1'b1;
                                state_next   = S_POP;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (dp_status.empty)
                            begin
                                ctrl_cmd.out_load   = 1'b1;
                                ctrl_cmd.out_status = ST_EMPTY;
                            end
                            else
                            begin
                                ctrl_cmd.dump_start = 1'b1;
                                state_next          = S_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (dp_status.out_free)
                begin
                    ctrl_cmd.out_load = 1'b1;
                    ctrl_cmd.out_sel  = SEL_RAM;
                    state_next        = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (dp_status.out_free)
                begin
                    ctrl_cmd.out_load = 1'b1;
                    ctrl_cmd.out_sel  = SEL_RAM;
                    ctrl_cmd.out_last = dp_status.idx_zero;
                    if (dp_status.idx_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctrl_cmd.dump_step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

@@ sv/lsd_datapath.sv @@
// ----------------------------------------------------------------------------
// lsd_datapath
// Stack storage, fill count, dump index and the response output register.
// ----------------------------------------------------------------------------
module lsd_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [lsd_pkg::WORD_W-1:0] cmd_value,
    input  lsd_pkg::ctrl_cmd_t                ctrl_cmd,
    output lsd_pkg::dp_status_t               dp_status,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output logic [lsd_pkg::STATUS_W-1:0]      rsp_status,
    output logic signed [lsd_pkg::WORD_W-1:0] rsp_data,
    output logic                              rsp_last
);
    import lsd_pkg::*;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [ADDR_W-1:0]   idx_reg;
    logic [ADDR_W-1:0]   idx_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [WORD_W-1:0]   out_data_reg;
    logic                out_last_reg;
    logic [WORD_W-1:0]   out_data_next;
    logic [CNT_W-1:0]    count_dec;
    logic [ADDR_W-1:0]   idx_dec;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    assign count_dec = count_reg - 1'b1;
    assign idx_dec   = idx_reg - 1'b1;

    assign ram_re    = ctrl_cmd.pop || ctrl_cmd.dump_start || ctrl_cmd.dump_step;
    assign ram_raddr = ctrl_cmd.dump_step ? idx_dec : count_dec[ADDR_W-1:0];

    lsd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl_cmd.push),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (cmd_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        if (ctrl_cmd.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl_cmd.pop)
        begin
            count_next = count_dec;
        end

        idx_next = idx_reg;
        if (ctrl_cmd.dump_start)
        begin
            idx_next = count_dec[ADDR_W-1:0];
        end
        else if (ctrl_cmd.dump_step)
        begin
            idx_next = idx_dec;
        end

        out_valid_next = out_valid_reg;
        if (ctrl_cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (ctrl_cmd.out_sel)
            SEL_ZERO: out_data_next = '0;
            SEL_ONES: out_data_next = '1;
            SEL_RAM:  out_data_next = ram_rdata;
            default:  out_data_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (ctrl_cmd.out_load)
        begin
            out_status_reg <= ctrl_cmd.out_status;
            out_data_reg   <= out_data_next;
            out_last_reg   <= ctrl_cmd.out_last;
        end
    end

    assign dp_status.empty    = (count_reg == '0);
    assign dp_status.full     = (count_reg == CNT_W'(DEPTH));
    assign dp_status.idx_zero = (idx_reg == '0);
    assign dp_status.out_free = !out_valid_reg || rsp_ready;

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = out_status_reg;
    assign rsp_data   = out_data_reg;
    assign rsp_last   = out_last_reg;
endmodule

@@ sv/lifo_stack_with_dump_core.sv @@
// Push, overflow, underflow and empty dump answer in the cycle after acceptance; a pop
// answers once its registered RAM read word is loaded into the output register.
// While the output is free, push and error cases take one request per cycle and a dump
// sends one word per cycle from the stack RAM; a pop or dump takes no request until done.
// Reset clears the fill count, the controller state and the output valid flag;
// stack contents are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
// lifo_stack_with_dump_core
// Top level of a fixed-depth LIFO stack with push, pop and top-to-bottom dump.
// ----------------------------------------------------------------------------
module lifo_stack_with_dump_core (
    input  logic      clk,
    input  logic      rst_n,
    lsd_cmd_if.sink   cmd,
    lsd_rsp_if.source rsp
);
    import lsd_pkg::*;

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    lsd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd.valid),
        .cmd_operation (cmd.operation),
        .cmd_ready     (cmd.ready),
        .dp_status     (dp_status),
        .ctrl_cmd      (ctrl_cmd)
    );

    lsd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_value  (cmd.value),
        .ctrl_cmd   (ctrl_cmd),
        .dp_status  (dp_status),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .rsp_status (rsp.status),
        .rsp_data   (rsp.data),
        .rsp_last   (rsp.last)
    );
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the LIFO stack with push, pop and dump.
// Requests go in over the command channel while a shadow stack in the
// testbench predicts every response. Responses are checked in order, field by
// field. The run covers empty, full and partly filled stacks, extreme data
// words, the unused operation code, and several patterns of idle and stall.
// ----------------------------------------------------------------------------
module tb;
    import lsd_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 25;

    typedef struct {
        status_t                  status;
        logic signed [WORD_W-1:0] data;
        logic                     last;
    } stack_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lsd_cmd_if cmd ();
    lsd_rsp_if rsp ();

    lifo_stack_with_dump_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    logic signed [WORD_W-1:0] shadow_words [DEPTH];
    int                       shadow_fill = 0;
    stack_rsp_t               pending_rsp [$];

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int error_count = 0;
    int items_sent = 0;
    int rsp_checked = 0;
    int dump_count = 0;
    int overflow_count = 0;
    int underflow_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        cmd.valid = 1'b0;
        cmd.operation = OP_PUSH;
        cmd.value = '0;
        rsp.ready = 1'b0;
    end

    task automatic predict_rsp(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] val);
        stack_rsp_t r;
        case (op)
            OP_PUSH:
            begin
                if (shadow_fill < DEPTH)
                begin
                    shadow_words[shadow_fill] = val;
                    shadow_fill++;
                    r = '{ST_OK, '0, 1'b1};
                end
                else
                begin
                    r = '{ST_OVERFLOW, '0, 1'b1};
                    overflow_count++;
                end
                pending_rsp.push_back(r);
            end
            OP_POP:
            begin
                if (shadow_fill > 0)
                begin
                    shadow_fill--;
                    r = '{ST_OK, shadow_words[shadow_fill], 1'b1};
                end
                else
                begin
                    r = '{ST_UNDERFLOW, '1, 1'b1};
                    underflow_count++;
                end
                pending_rsp.push_back(r);
            end
            OP_DUMP:
            begin
                dump_count++;
                if (shadow_fill == 0)
                begin
                    r = '{ST_EMPTY, '0, 1'b1};
                    pending_rsp.push_back(r);
                end
                else
                begin
                    for (int i = shadow_fill - 1; i >= 0; i--)
                    begin
                        r = '{ST_OK, shadow_words[i], (i == 0)};
                        pending_rsp.push_back(r);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] val);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.operation <= op;
        cmd.value <= val;
        predict_rsp(op, val);
        items_sent++;
        do
            @(posedge clk);
        while (!cmd.ready);
    endtask

    task automatic wait_drain();
        cmd.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        stack_rsp_t exp_rsp;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("Unexpected response transaction: status %0d data %0d last %0d",
                       rsp.status, rsp.data, rsp.last);
                error_count++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                rsp_checked++;
                if (rsp.status !== exp_rsp.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_rsp.status, rsp.status);
                    error_count++;
                end
                if (rsp.data !== exp_rsp.data)
                begin
                    $error("data mismatch: expected %0d, actual %0d", exp_rsp.data, rsp.data);
                    error_count++;
                end
                if (rsp.last !== exp_rsp.last)
                begin
                    $error("last mismatch: expected %0d, actual %0d", exp_rsp.last, rsp.last);
                    error_count++;
                end
            end
        end
        rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(11))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_item(OP_POP, 32'sh1234_5678);
        send_item(OP_DUMP, '1);
        send_item(OP_UNUSED, 32'sh5555_5555);
        send_item(OP_PUSH, 32'sh7FFF_FFFF);
        send_item(OP_PUSH, 32'sh8000_0000);
        send_item(OP_PUSH, '0);
        send_item(OP_PUSH, '1);
        send_item(OP_PUSH, 32'shAAAA_AAAA);
        send_item(OP_PUSH, 32'sh5555_5555);
        send_item(OP_DUMP, 32'sh0F0F_0F0F);
        send_item(OP_UNUSED, 32'shAAAA_AAAA);
        send_item(OP_POP, '0);
        send_item(OP_DUMP, '0);
        for (int i = 0; i < 6; i++)
            send_item(OP_POP, '1);
        send_item(OP_DUMP, '0);
        send_item(OP_PUSH, 32'sh0000_0001);
        send_item(OP_POP, '0);
        wait_drain();
    endtask

    task automatic test_full_stack();
        while (shadow_fill < DEPTH)
            send_item(OP_PUSH, pick_word());
        send_item(OP_PUSH, 32'sh7FFF_FFFF);
        send_item(OP_PUSH, 32'sh8000_0000);
        send_item(OP_DUMP, '0);
        send_item(OP_POP, '0);
        send_item(OP_PUSH, '1);
        send_item(OP_PUSH, '0);
        while (shadow_fill > 0)
            send_item(OP_POP, pick_word());
        send_item(OP_POP, '0);
        send_item(OP_DUMP, '0);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int push_pct, input bit pause_midway);
        int r;
        logic [OP_W-1:0] op;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(99);
            if (r < push_pct)
                op = OP_PUSH;
            else if (r < push_pct + (90 - push_pct) * 3 / 4)
                op = OP_POP;
            else if (r < 95)
                op = OP_DUMP;
            else
                op = OP_UNUSED;
            send_item(op, pick_word());
            if (pause_midway && n == RANDOM_ITEMS / 2)
                wait_drain();
        end
        wait_drain();
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int push_pct);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        test_random_traffic(push_pct, 1'b1);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_stack();

        run_phase(0, 0, 60);
        run_phase(73, 0, 40);
        run_phase(0, 73, 65);
        run_phase(36, 36, 45);

        src_idle_pct = 36;
        snk_stall_pct = 36;
        test_full_stack();

        wait_drain();
        $display("Sent %0d requests and checked %0d responses.", items_sent, rsp_checked);
        $display("Dumps %0d, overflows %0d, underflows %0d, under four idle/stall mixes.",
                 dump_count, overflow_count, underflow_count);
        if (error_count == 0 && pending_rsp.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
